// ===== rtl/core/thh_pkg.sv =====
// package: types, codes, reset values and threshold tables of the tank heater controller
`timescale 1ns / 1ps
package thh_pkg;

  localparam int unsigned TEMP_W  = 12;
  localparam int unsigned DELAY_W = 8;
  localparam int unsigned CFG_W   = 8;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    MODE_TICK       = 2'd0,
    MODE_LOAD_START = 2'd1,
    MODE_LOAD_LOW   = 2'd2,
    MODE_NONE       = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALTITUDE  = 2'd0,
    CFG_HOT_EN    = 2'd1,
    CFG_PERIOD    = 2'd2,
    CFG_LW_RELOAD = 2'd3
  } cfg_idx_t;

  localparam logic [1:0] PS_SAVE  = 2'd1;
  localparam logic [1:0] PS_SMART = 2'd2;

  localparam logic [1:0]         ALTITUDE_RST  = 2'd0;
  localparam logic               HOT_EN_RST    = 1'b1;
  localparam logic [CFG_W-1:0]   PERIOD_RST    = 8'd100;
  localparam logic [CFG_W-1:0]   LW_RELOAD_RST = 8'd100;

  localparam logic signed [TEMP_W-1:0] OVERHEAT_TENTHS = 12'sd1000;

  localparam logic signed [TEMP_W-1:0] OFF_TENTHS [3][4] = '{
    '{12'sd930, 12'sd880, 12'sd850, 12'sd820},
    '{12'sd930, 12'sd880, 12'sd850, 12'sd820},
    '{12'sd870, 12'sd820, 12'sd790, 12'sd760}
  };
  localparam logic signed [TEMP_W-1:0] ON_TENTHS [3][4] = '{
    '{12'sd830, 12'sd800, 12'sd770, 12'sd740},
    '{12'sd700, 12'sd700, 12'sd700, 12'sd700},
    '{12'sd600, 12'sd600, 12'sd600, 12'sd600}
  };

  typedef struct packed {
    logic [1:0]         altitude_mode;
    logic               hot_enabled;
    logic [CFG_W-1:0]   control_period;
    logic [CFG_W-1:0]   low_water_reload;
  } cfg_t;

  typedef struct packed {
    logic [1:0]                mode;
    logic [DELAY_W-1:0]        delay_value;
    logic                      key_lock;
    logic                      water_low;
    logic                      hot_error;
    logic                      first_fill_done;
    logic [1:0]                power_save;
    logic signed [TEMP_W-1:0]  tank_temp;
  } item_t;

  typedef struct packed {
    logic heater_on;
    logic control_step;
  } result_t;

  // power-save code to table row; unused code falls back to normal
  function automatic logic [1:0] table_sel(input logic [1:0] ps);
    logic [1:0] sel;
    case (ps)
      PS_SAVE:  sel = 2'd1;
      PS_SMART: sel = 2'd2;
      default:  sel = 2'd0;
    endcase
    return sel;
  endfunction

  function automatic logic signed [TEMP_W-1:0] off_thr(input logic [1:0] ps,
                                                       input logic [1:0] alt);
    return OFF_TENTHS[table_sel(ps)][alt];
  endfunction

  function automatic logic signed [TEMP_W-1:0] on_thr(input logic [1:0] ps,
                                                      input logic [1:0] alt);
    return ON_TENTHS[table_sel(ps)][alt];
  endfunction

endpackage

// ===== rtl/core/thh_if.sv =====
// interfaces: request and result channels of the tank heater controller
`timescale 1ns / 1ps
interface thh_in_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       mode;
  logic [thh_pkg::DELAY_W-1:0]      delay_value;
  logic                             key_lock;
  logic                             water_low;
  logic                             hot_error;
  logic                             first_fill_done;
  logic [1:0]                       power_save;
  logic signed [thh_pkg::TEMP_W-1:0] tank_temp;

  modport source (
    output valid, mode, delay_value, key_lock, water_low, hot_error,
           first_fill_done, power_save, tank_temp,
    input  ready
  );
  modport sink (
    input  valid, mode, delay_value, key_lock, water_low, hot_error,
           first_fill_done, power_save, tank_temp,
    output ready
  );
endinterface

interface thh_out_if;
  logic valid;
  logic ready;
  logic heater_on;
  logic control_step;

  modport source (output valid, heater_on, control_step, input ready);
  modport sink (input valid, heater_on, control_step, output ready);
endinterface

// ===== rtl/core/thh_ctrl.sv =====
// control state: prescaler, delay counters, priority checks and hysteresis
`timescale 1ns / 1ps
module thh_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  thh_pkg::item_t   item,
  input  thh_pkg::cfg_t    cfg,
  output thh_pkg::result_t res
);

  logic [7:0] period_count_r, period_count_nxt;
  logic [7:0] start_delay_r, start_delay_nxt;
  logic [7:0] low_water_delay_r, low_water_delay_nxt;
  logic       heater_r, heater_nxt;

  logic [7:0] period_inc;
  logic       run;
  logic signed [thh_pkg::TEMP_W-1:0] thr_off, thr_on;

  assign period_inc = (period_count_r < cfg.control_period) ?
                      period_count_r + 8'd1 : period_count_r;
  assign thr_off = thh_pkg::off_thr(item.power_save, cfg.altitude_mode);
  assign thr_on  = thh_pkg::on_thr(item.power_save, cfg.altitude_mode);

  always_comb begin
    period_count_nxt    = period_count_r;
    start_delay_nxt     = start_delay_r;
    low_water_delay_nxt = low_water_delay_r;
    heater_nxt          = heater_r;
    run                 = 1'b0;
    unique case (thh_pkg::mode_t'(item.mode))
      thh_pkg::MODE_LOAD_START: start_delay_nxt = item.delay_value;
      thh_pkg::MODE_LOAD_LOW:   low_water_delay_nxt = item.delay_value;
      thh_pkg::MODE_NONE:       ;
      thh_pkg::MODE_TICK: begin
        period_count_nxt = period_inc;
        if (period_inc >= cfg.control_period) begin
          period_count_nxt = '0;
          run              = 1'b1;
          if (start_delay_r != '0) begin
            start_delay_nxt = start_delay_r - 8'd1;
            heater_nxt      = 1'b0;
          end else if (item.key_lock || !cfg.hot_enabled) begin
            low_water_delay_nxt = '0;
            start_delay_nxt     = '0;
            heater_nxt          = 1'b0;
          end else if (item.water_low) begin
            low_water_delay_nxt = cfg.low_water_reload;
            heater_nxt          = 1'b0;
          end else if (low_water_delay_r != '0) begin
            low_water_delay_nxt = low_water_delay_r - 8'd1;
            heater_nxt          = 1'b0;
          end else if (!item.first_fill_done || item.hot_error) begin
            heater_nxt = 1'b0;
          end else begin
            // hysteresis band, then overheat cut
            if (item.tank_temp > thr_off) begin
              heater_nxt = 1'b0;
            end else if (item.tank_temp <= thr_on) begin
              heater_nxt = 1'b1;
            end
            if (item.tank_temp > thh_pkg::OVERHEAT_TENTHS) begin
              heater_nxt = 1'b0;
            end
          end
        end
      end
    endcase
  end

  assign res.heater_on    = heater_nxt;
  assign res.control_step = run;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_count_r    <= '0;
      start_delay_r     <= '0;
      low_water_delay_r <= '0;
      heater_r          <= 1'b0;
    end else if (fire) begin
      period_count_r    <= period_count_nxt;
      start_delay_r     <= start_delay_nxt;
      low_water_delay_r <= low_water_delay_nxt;
      heater_r          <= heater_nxt;
    end
  end

endmodule

// ===== rtl/core/tank_heater_hysteresis_control.sv =====
// top level: tank heater hysteresis thermostat with request and result registers
//
//   channel  | direction | handshake     | payload
//   in_chan  | sink      | valid / ready | mode, delay_value, readings, tank_temp
//   out_chan | source    | valid / ready | heater_on, control_step
//   cfg_*    | sink      | cfg_we only   | cfg_index, cfg_wdata
//
// one request per cycle sustained while out_chan is ready; each result passes the request and result registers.
// the request register feeds the control logic, whose state and the result register update together on fire.
// a stalled result holds in the result register while one more request waits behind it.
// synchronous active-low reset clears state, valids and configuration to defaults.
`timescale 1ns / 1ps
module tank_heater_hysteresis_control (
  input  logic                           clk,
  input  logic                           rst_n,
  thh_in_if.sink                         in_chan,
  thh_out_if.source                      out_chan,
  input  logic                           cfg_we,
  input  logic [thh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [thh_pkg::CFG_W-1:0]      cfg_wdata
);

  thh_pkg::cfg_t    cfg_r;
  thh_pkg::item_t   req_r;
  logic             req_valid_r;
  thh_pkg::result_t res_nxt;
  thh_pkg::result_t res_r;
  logic             res_valid_r;
  logic             fire;
  logic             in_fire;

  assign fire          = req_valid_r && (!res_valid_r || out_chan.ready);
  assign in_chan.ready = !req_valid_r || fire;
  assign in_fire       = in_chan.valid && in_chan.ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.altitude_mode    <= thh_pkg::ALTITUDE_RST;
      cfg_r.hot_enabled      <= thh_pkg::HOT_EN_RST;
      cfg_r.control_period   <= thh_pkg::PERIOD_RST;
      cfg_r.low_water_reload <= thh_pkg::LW_RELOAD_RST;
    end else if (cfg_we) begin
      unique case (thh_pkg::cfg_idx_t'(cfg_index))
        thh_pkg::CFG_ALTITUDE:  cfg_r.altitude_mode    <= cfg_wdata[1:0];
        thh_pkg::CFG_HOT_EN:    cfg_r.hot_enabled      <= cfg_wdata[0];
        thh_pkg::CFG_PERIOD:    cfg_r.control_period   <= cfg_wdata;
        thh_pkg::CFG_LW_RELOAD: cfg_r.low_water_reload <= cfg_wdata;
      endcase
    end
  end

  // request register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      req_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r.mode            <= in_chan.mode;
      req_r.delay_value     <= in_chan.delay_value;
      req_r.key_lock        <= in_chan.key_lock;
      req_r.water_low       <= in_chan.water_low;
      req_r.hot_error       <= in_chan.hot_error;
      req_r.first_fill_done <= in_chan.first_fill_done;
      req_r.power_save      <= in_chan.power_save;
      req_r.tank_temp       <= in_chan.tank_temp;
    end
  end

  thh_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (req_r),
    .cfg   (cfg_r),
    .res   (res_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (fire) begin
      res_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_chan.valid        = res_valid_r;
  assign out_chan.heater_on    = res_r.heater_on;
  assign out_chan.control_step = res_r.control_step;

endmodule
